>>> design/gain_command_parser_macros.svh
// Assertion macros shared by the gain command parser checkers.
`ifndef GAIN_COMMAND_PARSER_MACROS_SVH
`define GAIN_COMMAND_PARSER_MACROS_SVH

// Property that must hold in the cycle after a reset cycle.
`define GCP_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

// Property that must hold in the same cycle as its trigger.
`define GCP_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define GCP_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/gcp_pkg.sv
// Shared types, character codes and helpers for the gain command parser.
package gcp_pkg;

  localparam int BufferBytesDef  = 32;
  localparam int FractionBitsDef = 16;
  localparam int CmdqAw          = 2;

  localparam logic [7:0] CH_K_UP = 8'h4B;
  localparam logic [7:0] CH_K_LO = 8'h6B;
  localparam logic [7:0] CH_P_UP = 8'h50;
  localparam logic [7:0] CH_P_LO = 8'h70;
  localparam logic [7:0] CH_I_UP = 8'h49;
  localparam logic [7:0] CH_I_LO = 8'h69;
  localparam logic [7:0] CH_D_UP = 8'h44;
  localparam logic [7:0] CH_D_LO = 8'h64;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] GAIN_P = 2'd0;
  localparam logic [1:0] GAIN_I = 2'd1;
  localparam logic [1:0] GAIN_D = 2'd2;

  localparam logic [15:0] INT_CAP = 16'd32768;
  localparam logic [2:0]  MAX_FRAC_DIGITS = 3'd5;

  typedef struct packed {
    logic [1:0]  idx;
    logic        neg;
    logic [15:0] intg;
    logic [16:0] frac;
    logic [2:0]  digits;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic        neg;
    logic [15:0] intg;
  } tag_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] value;
  } res_t;

  function automatic logic [16:0] pow_ten(input logic [2:0] n);
    logic [16:0] p;
    unique case (n)
      3'd0: p = 17'd1;
      3'd1: p = 17'd10;
      3'd2: p = 17'd100;
      3'd3: p = 17'd1000;
      3'd4: p = 17'd10000;
      3'd5: p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // Result queue address width: deep enough to cover the whole value pipeline.
  function automatic int out_aw(input int fb);
    return $clog2(fb + 4);
  endfunction

endpackage

>>> design/gcp_fifo.sv
// Register-based first-in first-out queue used between the parser stages.
module gcp_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int Depth = 1 << AW;

  logic [WIDTH-1:0] mem [Depth];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

>>> design/gcp_front.sv
// Byte parser: finds commands and accumulates the decimal number as it arrives.
module gcp_front #(
  parameter int BUFFER_BYTES = gcp_pkg::BufferBytesDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  output logic          cmd_push,
  output gcp_pkg::cmd_t cmd
);
  import gcp_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES);
  localparam logic [CW-1:0] CountLimit = CW'(BUFFER_BYTES - 1);

  typedef enum logic [1:0] {PH_HEAD, PH_FLAG, PH_DATA} phase_t;

  phase_t        phase, phase_next;
  logic [1:0]    sel, sel_next;
  logic [CW-1:0] char_count, char_count_next;
  logic          neg, neg_next;
  logic          point_seen, point_seen_next;
  logic          stopped, stopped_next;
  logic          body, body_next;
  logic [2:0]    digits, digits_next;
  logic [15:0]   int_accum, int_accum_next;
  logic [16:0]   frac_accum, frac_accum_next;

  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit;
  logic [18:0] int_prod;
  logic [19:0] frac_prod;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign digit    = rx_byte[3:0];
  // Times ten as two shifts and an add.
  assign int_prod  = ({3'b0, int_accum} << 3) + ({3'b0, int_accum} << 1) + 19'(digit);
  assign frac_prod = ({3'b0, frac_accum} << 3) + ({3'b0, frac_accum} << 1) + 20'(digit);

  always_comb begin
    phase_next      = phase;
    sel_next        = sel;
    char_count_next = char_count;
    neg_next        = neg;
    point_seen_next = point_seen;
    stopped_next    = stopped;
    body_next       = body;
    digits_next     = digits;
    int_accum_next  = int_accum;
    frac_accum_next = frac_accum;
    cmd_push        = 1'b0;
    if (take) begin
      unique case (phase)
        PH_FLAG: begin
          priority if (rx_byte == CH_P_UP || rx_byte == CH_P_LO) begin
            sel_next   = GAIN_P;
            phase_next = PH_DATA;
          end else if (rx_byte == CH_I_UP || rx_byte == CH_I_LO) begin
            sel_next   = GAIN_I;
            phase_next = PH_DATA;
          end else if (rx_byte == CH_D_UP || rx_byte == CH_D_LO) begin
            sel_next   = GAIN_D;
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_HEAD;
          end
          char_count_next = '0;
          neg_next        = 1'b0;
          point_seen_next = 1'b0;
          stopped_next    = 1'b0;
          body_next       = 1'b0;
          digits_next     = '0;
          int_accum_next  = '0;
          frac_accum_next = '0;
        end
        PH_DATA: begin
          if (rx_byte == CH_BANG) begin
            cmd_push   = 1'b1;
            phase_next = PH_HEAD;
          end else if (char_count < CountLimit) begin
            char_count_next = char_count + 1'b1;
            // The first character that fits no part of the number freezes it.
            priority if (stopped) begin
              stopped_next = 1'b1;
            end else if (!body && is_space) begin
              body_next = 1'b0;
            end else if (!body && (rx_byte == CH_PLUS || rx_byte == CH_MINUS)) begin
              body_next = 1'b1;
              neg_next  = (rx_byte == CH_MINUS);
            end else if (is_digit) begin
              body_next = 1'b1;
              if (point_seen) begin
                if (digits < MAX_FRAC_DIGITS) begin
                  frac_accum_next = frac_prod[16:0];
                  digits_next     = digits + 1'b1;
                end
              end else begin
                int_accum_next = (int_prod > 19'(INT_CAP)) ? INT_CAP : int_prod[15:0];
              end
            end else if (rx_byte == CH_POINT && !point_seen) begin
              body_next       = 1'b1;
              point_seen_next = 1'b1;
            end else begin
              stopped_next = 1'b1;
            end
          end
        end
        default: begin
          if (rx_byte == CH_K_UP || rx_byte == CH_K_LO) begin
            phase_next      = PH_FLAG;
            char_count_next = '0;
            neg_next        = 1'b0;
            point_seen_next = 1'b0;
            stopped_next    = 1'b0;
            body_next       = 1'b0;
            digits_next     = '0;
            int_accum_next  = '0;
            frac_accum_next = '0;
          end else begin
            phase_next = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      sel        <= GAIN_P;
      char_count <= '0;
      neg        <= 1'b0;
      point_seen <= 1'b0;
      stopped    <= 1'b0;
      body       <= 1'b0;
      digits     <= '0;
      int_accum  <= '0;
      frac_accum <= '0;
    end else begin
      phase      <= phase_next;
      sel        <= sel_next;
      char_count <= char_count_next;
      neg        <= neg_next;
      point_seen <= point_seen_next;
      stopped    <= stopped_next;
      body       <= body_next;
      digits     <= digits_next;
      int_accum  <= int_accum_next;
      frac_accum <= frac_accum_next;
    end
  end

  always_comb begin
    cmd.idx    = sel;
    cmd.neg    = neg;
    cmd.intg   = int_accum;
    cmd.frac   = frac_accum;
    cmd.digits = digits;
  end
endmodule

>>> design/gcp_back.sv
// Value pipeline: scales the decimal fraction to binary and saturates the gain.
module gcp_back #(
  parameter int FRACTION_BITS = gcp_pkg::FractionBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  gcp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_taken,
  output logic          res_push,
  output gcp_pkg::res_t res
);
  import gcp_pkg::*;

  localparam int FB    = FRACTION_BITS;
  localparam int OutAw = out_aw(FRACTION_BITS);
  localparam int MagW  = 16 + FB + 1;
  localparam int CmpW  = (MagW > 33) ? MagW : 33;

  // Words in the pipeline plus words in the result queue.
  logic [OutAw:0] used;
  logic           issue;

  logic [FB:0]    st_valid;
  logic [16:0]    st_rem [FB+1];
  logic [16:0]    st_div [FB+1];
  logic [FB-1:0]  st_quo [FB+1];
  tag_t           st_tag [FB+1];

  logic [16:0]    rem_step [FB];
  logic           ge_step  [FB];

  logic           r_valid;
  logic [FB:0]    r_frac;
  tag_t           r_tag;
  logic [17:0]    rsum;
  logic           rbit;

  logic           m_valid;
  logic [MagW-1:0] m_mag;
  tag_t           m_tag;
  logic [CmpW-1:0] magx;
  logic [31:0]    value;

  assign issue   = !cmd_empty && (used != (OutAw+1)'(1 << OutAw));
  assign cmd_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + (OutAw+1)'(issue) - (OutAw+1)'(res_taken);
    end
  end

  // One restoring division step per stage; the remainder always stays below the divisor.
  always_comb begin
    for (int k = 0; k < FB; k++) begin
      logic [17:0] twice;
      logic [17:0] diff;
      twice       = {st_rem[k], 1'b0};
      diff        = twice - {1'b0, st_div[k]};
      ge_step[k]  = (twice >= {1'b0, st_div[k]});
      rem_step[k] = ge_step[k] ? diff[16:0] : twice[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      st_valid <= {st_valid[FB-1:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    st_rem[0] <= cmd.frac;
    st_div[0] <= pow_ten(cmd.digits);
    st_quo[0] <= '0;
    st_tag[0] <= '{idx: cmd.idx, neg: cmd.neg, intg: cmd.intg};
    for (int k = 0; k < FB; k++) begin
      st_rem[k+1] <= rem_step[k];
      st_div[k+1] <= st_div[k];
      st_quo[k+1] <= {st_quo[k][FB-2:0], ge_step[k]};
      st_tag[k+1] <= st_tag[k];
    end
  end

  // Round half up: add one when the remainder reaches half the divisor.
  assign rsum = {1'b0, st_rem[FB]} + {2'b0, st_div[FB][16:1]};
  assign rbit = (rsum >= {1'b0, st_div[FB]});

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      r_valid <= st_valid[FB];
      m_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_frac <= {1'b0, st_quo[FB]} + (FB+1)'(rbit);
    r_tag  <= st_tag[FB];
    m_mag  <= {1'b0, r_tag.intg, {FB{1'b0}}} + MagW'(r_frac);
    m_tag  <= r_tag;
  end

  assign magx = CmpW'(m_mag);

  always_comb begin
    if (m_tag.neg) begin
      value = (magx > CmpW'(64'h8000_0000)) ? 32'h8000_0000 : (32'd0 - magx[31:0]);
    end else begin
      value = (magx > CmpW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : magx[31:0];
    end
  end

  assign res_push  = m_valid;
  assign res.idx   = m_tag.idx;
  assign res.value = value;
endmodule

>>> design/gain_command_parser.sv
// Gain command parser top level: byte parser, command queue, value pipeline, result queue.
//
//   channel   direction  handshake           word
//   input     in         push / full         rx_byte (one ASCII character)
//   result    out        empty / pop         gain_index, gain_value (Q15.16 default)
//
// One byte is taken every cycle while full is low; the parser has no multi-cycle step.
// After its '!' is taken, a command passes the command queue, the quotient pipeline that
// spends one stage on each fraction bit, and the rounding and sum registers.
// Reset is synchronous and clears all control state; the queues come out empty.
// A stalled result side fills the result queue, then the 4-word command queue; full
// is raised only when that command queue is full.
module gain_command_parser #(
  parameter int BUFFER_BYTES  = gcp_pkg::BufferBytesDef,
  parameter int FRACTION_BITS = gcp_pkg::FractionBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         gain_index,
  output logic signed [31:0] gain_value
);
  import gcp_pkg::*;

  localparam int OutAw = out_aw(FRACTION_BITS);

  logic take;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  res_t res_out;
  logic res_full;

  assign take = push && !full;

  gcp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  gcp_fifo #(.WIDTH($bits(cmd_t)), .AW(CmdqAw)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  gcp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_taken (pop && !empty),
    .res_push  (res_push),
    .res       (res_in)
  );

  // The value pipeline only issues against free slots here, so res_full never blocks a push.
  gcp_fifo #(.WIDTH($bits(res_t)), .AW(OutAw)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push && !res_full),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign gain_index = res_out.idx;
  assign gain_value = $signed(res_out.value);
endmodule

>>> design/gcp_checker.sv
// Port-level checker for the gain command parser and its bind.
`include "gain_command_parser_macros.svh"

module gcp_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         gain_index,
  input logic signed [31:0] gain_value
);
  import gcp_pkg::*;

  `GCP_AFTER_RESET(a_reset_clears, !full && empty, "queues not clear after reset")
  // The shortest command is three bytes, so no word can show right after reset.
  `GCP_AFTER_RESET(a_no_early_word, empty ##1 empty ##1 empty, "word too soon after reset")
  `GCP_HOLDS(a_index_range, !empty, gain_index <= GAIN_D, "gain index out of range")
  `GCP_NEXT(a_word_held, !empty && !pop, !empty && $stable(gain_index) && $stable(gain_value), "waiting word changed")
endmodule

bind gain_command_parser gcp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .gain_index (gain_index),
  .gain_value (gain_value)
);

>>> test/tb_top.sv
// Self-checking testbench for the gain command parser with a built-in command predictor.
module tb_top;
  import gcp_pkg::*;

  localparam int FracBits    = FractionBitsDef;
  localparam int BufBytes    = BufferBytesDef;
  localparam int DrainCycles = 2 * (FracBits + 4) + 8;
  localparam int RandomBytes = 1500;

  typedef enum logic [1:0] {HUNT_HEAD, HUNT_GAIN, TAKE_NUMBER} parse_phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte = 8'h00;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         gain_index;
  logic signed [31:0] gain_value;

  // Predictor state.
  parse_phase_t phase = HUNT_HEAD;
  logic [1:0]   gain_sel = GAIN_P;
  logic [4:0]   num_chars = '0;
  logic         num_negative = 1'b0;
  logic         num_point = 1'b0;
  logic         num_done = 1'b0;
  logic         num_started = 1'b0;
  logic [2:0]   frac_count = '0;
  logic [15:0]  int_part = '0;
  logic [16:0]  frac_part = '0;
  logic [31:0]  stored_gain [3] = '{32'd0, 32'd0, 32'd0};

  res_t gain_updates[$];
  res_t oldest_update;
  int   mismatches = 0;
  int   burst_left = 0;
  int   stall_left = 0;
  int   rx_cycle = 0;
  int   random_bytes_sent = 0;

  gain_command_parser dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .gain_index (gain_index),
    .gain_value (gain_value)
  );

  always #5 clk = ~clk;

  function automatic logic [16:0] decimal_scale(input logic [2:0] n);
    case (n)
      3'd1: return 17'd10;
      3'd2: return 17'd100;
      3'd3: return 17'd1000;
      3'd4: return 17'd10000;
      3'd5: return 17'd100000;
      default: return 17'd1;
    endcase
  endfunction

  function automatic void clear_number();
    num_chars = '0;
    num_negative = 1'b0;
    num_point = 1'b0;
    num_done = 1'b0;
    num_started = 1'b0;
    frac_count = '0;
    int_part = '0;
    frac_part = '0;
  endfunction

  function automatic void take_number_char(input logic [7:0] c);
    logic [31:0] grown;
    if (num_done) return;
    if (!num_started && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) return;
    if (!num_started && (c == CH_PLUS || c == CH_MINUS)) begin
      num_started = 1'b1;
      num_negative = (c == CH_MINUS);
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      num_started = 1'b1;
      if (num_point) begin
        // Fraction digits past the fifth are consumed without effect.
        if (frac_count < MAX_FRAC_DIGITS) begin
          frac_part = frac_part * 17'd10 + {9'd0, c - CH_ZERO};
          frac_count = frac_count + 3'd1;
        end
      end else begin
        grown = {16'd0, int_part} * 32'd10 + {24'd0, c - CH_ZERO};
        int_part = (grown > INT_CAP) ? INT_CAP : grown[15:0];
      end
      return;
    end
    if (c == CH_POINT && !num_point) begin
      num_started = 1'b1;
      num_point = 1'b1;
      return;
    end
    num_done = 1'b1;
  endfunction

  // Integer part plus the kept fraction, rounded half up, then saturated.
  function automatic logic [31:0] fixed_point_value();
    logic [63:0] scale;
    logic [63:0] frac;
    logic [63:0] mag;
    scale = {47'd0, decimal_scale(frac_count)};
    frac = (({47'd0, frac_part} << FracBits) + scale / 2) / scale;
    mag = ({48'd0, int_part} << FracBits) + frac;
    if (num_negative) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic void predict_gain_update(input logic [7:0] c);
    logic [31:0] v;
    res_t        entry;
    case (phase)
      HUNT_GAIN: begin
        if (c == CH_P_UP || c == CH_P_LO) begin
          gain_sel = GAIN_P;
          phase = TAKE_NUMBER;
        end else if (c == CH_I_UP || c == CH_I_LO) begin
          gain_sel = GAIN_I;
          phase = TAKE_NUMBER;
        end else if (c == CH_D_UP || c == CH_D_LO) begin
          gain_sel = GAIN_D;
          phase = TAKE_NUMBER;
        end else begin
          phase = HUNT_HEAD;
        end
        clear_number();
      end
      TAKE_NUMBER: begin
        if (c == CH_BANG) begin
          v = fixed_point_value();
          stored_gain[gain_sel] = v;
          entry.idx = gain_sel;
          entry.value = v;
          gain_updates.push_back(entry);
          phase = HUNT_HEAD;
        end else if (num_chars < BufBytes - 1) begin
          num_chars = num_chars + 5'd1;
          take_number_char(c);
        end
      end
      default: begin
        if (c == CH_K_UP || c == CH_K_LO) begin
          phase = HUNT_GAIN;
          clear_number();
        end else begin
          phase = HUNT_HEAD;
        end
      end
    endcase
  endfunction

  // Offers one word, waits until it is taken, then maybe opens a gap before the next burst.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_gain_update(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        rx_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // The sender goes idle until every predicted word has been taken.
  task automatic wait_for_updates();
    push <= 1'b0;
    @(posedge clk);
    while (gain_updates.size() != 0) @(posedge clk);
  endtask

  task automatic test_extreme_values();
    send_text("KP32767.99999!");
    send_text("kI-32768!");
    send_text("Kd99999!");
    send_text("kp-99999.5!");
    send_text("kD0!");
    send_text("Kp-0!");
    send_text("ki0.00001!");
    send_text("kd-0.5!");
  endtask

  task automatic test_number_forms();
    send_text("ki!");
    send_text("kd-!");
    send_text("kp.!");
    send_text("kp+.!");
    // Leading white space of every kind, then a signed value.
    send_text("kp");
    send_byte(CH_SPACE);
    send_byte(CH_TAB);
    send_byte(8'h0A);
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_byte(CH_CR);
    send_text("+1.5!");
    send_text("ki0.1234567!");
    send_text("kd1.2.3!");
    send_text("kp12-3!");
    send_text("kp1a2!");
    send_text("ki1");
    send_byte(8'h00);
    send_text("9!");
  endtask

  task automatic test_long_numbers();
    // Only 31 characters after the gain letter are looked at.
    send_text("kI");
    repeat (30) send_byte(CH_ZERO);
    send_text("75999!");
    send_text("kd");
    repeat (BufBytes) send_byte(CH_SPACE);
    send_text("5!");
    send_text("kp");
    repeat (40) send_byte("9");
    send_byte(CH_BANG);
  endtask

  task automatic test_broken_commands();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("!xyz");
    send_text("kx1!");
    send_text("kk!");
    send_text("K!");
    send_text("KpKi3!");
    send_text("kP5kD7!");
  endtask

  task automatic test_drain_pause();
    send_text("kd-1.25!");
    wait_for_updates();
    send_text("kp3!ki-2.75!");
    wait_for_updates();
  endtask

  task automatic random_command();
    logic [7:0] cmd[$];
    logic [7:0] pick;
    int         n;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 24) == 0) cmd.push_back(8'($urandom_range(0, 255)));
    else cmd.push_back($urandom_range(0, 1) ? CH_K_UP : CH_K_LO);
    if ($urandom_range(0, 19) == 0) begin
      cmd.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0: pick = CH_P_UP;
        1: pick = CH_P_LO;
        2: pick = CH_I_UP;
        3: pick = CH_I_LO;
        4: pick = CH_D_UP;
        default: pick = CH_D_LO;
      endcase
      cmd.push_back(pick);
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) cmd.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
    case ($urandom_range(0, 2))
      1: cmd.push_back(CH_PLUS);
      2: cmd.push_back(CH_MINUS);
      default: ;
    endcase
    // Mostly short numbers; now and then one long enough to saturate or overrun.
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 35) : $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && n == 5 && $urandom_range(0, 1)) cmd.push_back("3");
      else cmd.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) < 6) begin
      cmd.push_back(CH_POINT);
      repeat ($urandom_range(0, 7)) cmd.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) == 0) begin
      cmd.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) cmd.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 19) != 0) cmd.push_back(CH_BANG);
    foreach (cmd[i]) send_byte(cmd[i]);
    random_bytes_sent += cmd.size();
  endtask

  task automatic test_random_commands();
    while (random_bytes_sent < RandomBytes) random_command();
  endtask

  // Result side: check every word taken, then choose the next pop.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst && pop && !empty) begin
      if (gain_updates.size() == 0) begin
        $error("result word with no command waiting: index %0d value %0d",
               gain_index, gain_value);
        mismatches++;
      end else begin
        oldest_update = gain_updates.pop_front();
        if (gain_index !== oldest_update.idx) begin
          $error("gain_index: expected %0d, got %0d", oldest_update.idx, gain_index);
          mismatches++;
        end
        if (gain_value !== oldest_update.value) begin
          $error("gain_value: expected %0d, got %0d",
                 $signed(oldest_update.value), gain_value);
          mismatches++;
        end
      end
    end
    if (rx_cycle[9:8] == 2'b00) begin
      pop <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 30);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_values();
    test_number_forms();
    test_long_numbers();
    test_broken_commands();
    test_drain_pause();
    test_random_commands();
    wait_for_updates();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && gain_updates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/gcp_pkg.sv
design/gcp_fifo.sv
design/gcp_front.sv
design/gcp_back.sv
design/gain_command_parser.sv
design/gcp_checker.sv
test/tb_top.sv
